>>> rtl/cluster_frustum_distance_cull_macros.svh
// Assertion macros used by the checker file of the culling block.
// Standalone header; no dependencies.
`ifndef CLUSTER_FRUSTUM_DISTANCE_CULL_MACROS_SVH
`define CLUSTER_FRUSTUM_DISTANCE_CULL_MACROS_SVH

// same-cycle implication, disabled during reset
`define CFDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CFDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cfdc_pkg.sv
// Types and constants for the cluster frustum/distance cull block.
// No dependencies.
package cfdc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int TALLY_BITS_DEF = 32;
	localparam int NUM_PLANES     = 6;
	localparam int NUM_AXES       = 3;
	localparam int REG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;
	localparam int FIELD_W        = 16;
	localparam int FRAC_BITS      = 14;
	localparam int CLAMP_W        = 18;
	localparam int AXIS_CLAMP     = 1 << 17;
	localparam int SQ_W           = 2 * CLAMP_W;
	localparam int THR_SQ_W       = 2 * FIELD_W;
	localparam int CLUSTER_W      = 16;
	localparam int TREE_OUT_W     = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PLANE_A,
		REG_PLANE_B,
		REG_PLANE_C,
		REG_PLANE_D,
		REG_PLANE_E,
		REG_PLANE_F,
		REG_CAMERA,
		REG_DISTANCE
	} reg_idx_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] w;
		logic signed [FIELD_W-1:0] nz;
		logic signed [FIELD_W-1:0] ny;
		logic signed [FIELD_W-1:0] nx;
	} plane_t;

	typedef struct packed {
		plane_t [NUM_PLANES-1:0]   plane;
		logic signed [FIELD_W-1:0] cam_z;
		logic signed [FIELD_W-1:0] cam_y;
		logic signed [FIELD_W-1:0] cam_x;
		logic [FIELD_W-1:0]        imp_dist;
		logic [FIELD_W-1:0]        cull_dist;
		logic                      lod_en;
		logic                      cull_en;
	} cfg_t;

endpackage

>>> rtl/cluster_frustum_distance_cull.sv
// Cluster sphere culling against six planes and a cull distance, with impostor flag.
// Pipeline: input, multiply and result registers between request accept and out_valid.
// Throughput: one request per cycle; each stage holds only while the one after is full.
// Reset (arst_n low, async): clears stage valids, configuration and pass totals.
// Depends on cfdc_pkg, cfdc_cfg, cfdc_mul, cfdc_judge.
module cluster_frustum_distance_cull import cfdc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TALLY_BITS = TALLY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [REG_IDX_W-1:0]         wr_index,
	input  logic [CFG_DATA_W-1:0]        wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic signed [COORD_BITS-1:0] center_z,
	input  logic [FIELD_W-1:0]           sphere_radius,
	input  logic [FIELD_W-1:0]           tree_count,
	input  logic                         pass_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         cluster_visible,
	output logic                         use_impostor,
	output logic [FIELD_W-1:0]           trees_shown,
	output logic [CLUSTER_W-1:0]         visible_cluster_total,
	output logic [TREE_OUT_W-1:0]        visible_tree_total
);

	cfg_t cfg;

	logic valid_s1;
	logic valid_s2;
	logic valid_q;
	logic en_s1;
	logic en_s2;
	logic en_out;

	logic signed [FIELD_W+COORD_BITS-1:0] prod_s2 [NUM_PLANES][NUM_AXES];
	logic [SQ_W-1:0]      sq_s2 [NUM_AXES];
	logic [THR_SQ_W-1:0]  cull_sq_s2;
	logic [THR_SQ_W-1:0]  imp_sq_s2;
	logic [FIELD_W-1:0]   radius_s2;
	logic [FIELD_W-1:0]   trees_s2;
	logic                 pass_s2;

	assign en_out   = !valid_q || out_ready;
	assign en_s2    = !valid_s2 || en_out;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= in_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_out)
				valid_q <= valid_s2;
		end
	end

	cfdc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	cfdc_mul #(
		.COORD_BITS (COORD_BITS)
	) u_mul (
		.clk           (clk),
		.en_s1         (en_s1),
		.en_s2         (en_s2),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.sphere_radius (sphere_radius),
		.tree_count    (tree_count),
		.pass_start    (pass_start),
		.cfg           (cfg),
		.prod_s2       (prod_s2),
		.sq_s2         (sq_s2),
		.cull_sq_s2    (cull_sq_s2),
		.imp_sq_s2     (imp_sq_s2),
		.radius_s2     (radius_s2),
		.trees_s2      (trees_s2),
		.pass_s2       (pass_s2)
	);

	cfdc_judge #(
		.COORD_BITS (COORD_BITS),
		.TALLY_BITS (TALLY_BITS)
	) u_judge (
		.clk                   (clk),
		.arst_n                (arst_n),
		.load                  (en_out && valid_s2),
		.cfg                   (cfg),
		.prod_s2               (prod_s2),
		.sq_s2                 (sq_s2),
		.cull_sq_s2            (cull_sq_s2),
		.imp_sq_s2             (imp_sq_s2),
		.radius_s2             (radius_s2),
		.trees_s2              (trees_s2),
		.pass_s2               (pass_s2),
		.cluster_visible       (cluster_visible),
		.use_impostor          (use_impostor),
		.trees_shown           (trees_shown),
		.visible_cluster_total (visible_cluster_total),
		.visible_tree_total    (visible_tree_total)
	);

endmodule

>>> rtl/cfdc_cfg.sv
// Configuration register file: planes, camera position, distance settings.
// Depends on cfdc_pkg.
module cfdc_cfg import cfdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index)) inside
				REG_PLANE_A, REG_PLANE_B, REG_PLANE_C,
				REG_PLANE_D, REG_PLANE_E, REG_PLANE_F: begin
					cfg_q.plane[wr_index] <= plane_t'(wr_data);
				end
				REG_CAMERA: begin
					cfg_q.cam_x <= wr_data[15:0];
					cfg_q.cam_y <= wr_data[31:16];
					cfg_q.cam_z <= wr_data[47:32];
				end
				REG_DISTANCE: begin
					cfg_q.cull_dist <= wr_data[15:0];
					cfg_q.imp_dist  <= wr_data[31:16];
					cfg_q.cull_en   <= wr_data[32];
					cfg_q.lod_en    <= wr_data[33];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/cfdc_mul.sv
// Input register and multiply stage: plane dot-product terms, clamped axis
// squares and squared thresholds. Depends on cfdc_pkg.
module cfdc_mul import cfdc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en_s1,
	input  logic                          en_s2,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic signed [COORD_BITS-1:0]  center_z,
	input  logic [FIELD_W-1:0]            sphere_radius,
	input  logic [FIELD_W-1:0]            tree_count,
	input  logic                          pass_start,
	input  cfg_t                          cfg,
	output logic signed [FIELD_W+COORD_BITS-1:0] prod_s2 [NUM_PLANES][NUM_AXES],
	output logic [SQ_W-1:0]               sq_s2 [NUM_AXES],
	output logic [THR_SQ_W-1:0]           cull_sq_s2,
	output logic [THR_SQ_W-1:0]           imp_sq_s2,
	output logic [FIELD_W-1:0]            radius_s2,
	output logic [FIELD_W-1:0]            trees_s2,
	output logic                          pass_s2
);

	localparam int DW = ((COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W) + 1;
	localparam int MW = (DW > CLAMP_W) ? DW : CLAMP_W;

	logic signed [COORD_BITS-1:0] c_s1 [NUM_AXES];
	logic [FIELD_W-1:0]           radius_s1;
	logic [FIELD_W-1:0]           trees_s1;
	logic                         pass_s1;

	logic signed [FIELD_W-1:0] cam [NUM_AXES];
	logic signed [FIELD_W-1:0] n   [NUM_PLANES][NUM_AXES];
	logic signed [DW-1:0]      diff [NUM_AXES];
	logic [MW-1:0]             mag  [NUM_AXES];
	logic [CLAMP_W-1:0]        m    [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			c_s1[0]   <= center_x;
			c_s1[1]   <= center_y;
			c_s1[2]   <= center_z;
			radius_s1 <= sphere_radius;
			trees_s1  <= tree_count;
			pass_s1   <= pass_start;
		end
	end

	always_comb begin
		cam[0] = cfg.cam_x;
		cam[1] = cfg.cam_y;
		cam[2] = cfg.cam_z;
		for (int p = 0; p < NUM_PLANES; p++) begin
			n[p][0] = cfg.plane[p].nx;
			n[p][1] = cfg.plane[p].ny;
			n[p][2] = cfg.plane[p].nz;
		end
		for (int k = 0; k < NUM_AXES; k++) begin
			diff[k] = DW'(c_s1[k]) - DW'(cam[k]);
			mag[k]  = MW'((diff[k] < 0) ? -diff[k] : diff[k]);
			// far axis distances clamp to 2^17; thresholds are only 16 bits
			m[k]    = (mag[k] > MW'(AXIS_CLAMP)) ? CLAMP_W'(AXIS_CLAMP) : mag[k][CLAMP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int k = 0; k < NUM_AXES; k++) begin
					prod_s2[p][k] <= n[p][k] * c_s1[k];
				end
			end
			for (int k = 0; k < NUM_AXES; k++) begin
				sq_s2[k] <= m[k] * m[k];
			end
			cull_sq_s2 <= cfg.cull_dist * cfg.cull_dist;
			imp_sq_s2  <= cfg.imp_dist * cfg.imp_dist;
			radius_s2  <= radius_s1;
			trees_s2   <= trees_s1;
			pass_s2    <= pass_s1;
		end
	end

endmodule

>>> rtl/cfdc_judge.sv
// Decision and result stage: plane and distance compares, visibility,
// impostor flag, saturating pass totals. Depends on cfdc_pkg.
module cfdc_judge import cfdc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TALLY_BITS = TALLY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  cfg_t                          cfg,
	input  logic signed [FIELD_W+COORD_BITS-1:0] prod_s2 [NUM_PLANES][NUM_AXES],
	input  logic [SQ_W-1:0]               sq_s2 [NUM_AXES],
	input  logic [THR_SQ_W-1:0]           cull_sq_s2,
	input  logic [THR_SQ_W-1:0]           imp_sq_s2,
	input  logic [FIELD_W-1:0]            radius_s2,
	input  logic [FIELD_W-1:0]            trees_s2,
	input  logic                          pass_s2,
	output logic                          cluster_visible,
	output logic                          use_impostor,
	output logic [FIELD_W-1:0]            trees_shown,
	output logic [CLUSTER_W-1:0]          visible_cluster_total,
	output logic [TREE_OUT_W-1:0]         visible_tree_total
);

	localparam int PW     = (FIELD_W + COORD_BITS + 3 > 33) ? FIELD_W + COORD_BITS + 3 : 33;
	localparam int TSUM_W = TALLY_BITS + 1;
	localparam logic [TREE_OUT_W-1:0] TREE_OUT_MAX = '1;

	logic signed [PW-1:0]   acc [NUM_PLANES];
	logic signed [PW-1:0]   lim;
	logic [NUM_PLANES-1:0]  behind;
	logic [SQ_W-1:0]        d2;
	logic                   far_cull;
	logic                   far_imp;
	logic                   vis;
	logic                   imp;

	logic [CLUSTER_W-1:0]   cluster_tally_q;
	logic [TALLY_BITS-1:0]  tree_tally_q;
	logic [CLUSTER_W-1:0]   c_base;
	logic [CLUSTER_W-1:0]   c_next;
	logic [TALLY_BITS-1:0]  t_base;
	logic [TALLY_BITS-1:0]  t_next;
	logic [TSUM_W-1:0]      t_sum;

	logic                   visible_q;
	logic                   impostor_q;
	logic [FIELD_W-1:0]     trees_q;

	always_comb begin
		lim = -(PW'($signed({1'b0, radius_s2})) <<< FRAC_BITS);
		for (int p = 0; p < NUM_PLANES; p++) begin
			acc[p] = PW'(prod_s2[p][0]) + PW'(prod_s2[p][1]) + PW'(prod_s2[p][2])
				+ (PW'(cfg.plane[p].w) <<< FRAC_BITS);
			behind[p] = acc[p] < lim;
		end
		d2       = sq_s2[0] + sq_s2[1] + sq_s2[2];
		far_cull = d2 > SQ_W'(cull_sq_s2);
		far_imp  = d2 > SQ_W'(imp_sq_s2);
		vis      = (trees_s2 != '0) && !(cfg.cull_en && (far_cull || (|behind)));
		imp      = vis && cfg.lod_en && far_imp;

		c_base = pass_s2 ? '0 : cluster_tally_q;
		t_base = pass_s2 ? '0 : tree_tally_q;
		c_next = (vis && (c_base != '1)) ? c_base + CLUSTER_W'(1) : c_base;
		t_sum  = {1'b0, t_base} + TSUM_W'(trees_s2);
		if (!vis)
			t_next = t_base;
		else if (t_sum[TALLY_BITS])
			t_next = '1;
		else
			t_next = t_sum[TALLY_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_tally_q <= '0;
			tree_tally_q    <= '0;
		end else if (load) begin
			cluster_tally_q <= c_next;
			tree_tally_q    <= t_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			visible_q  <= vis;
			impostor_q <= imp;
			trees_q    <= vis ? trees_s2 : '0;
		end
	end

	assign cluster_visible       = visible_q;
	assign use_impostor          = impostor_q;
	assign trees_shown           = trees_q;
	assign visible_cluster_total = cluster_tally_q;
	assign visible_tree_total    = (tree_tally_q > TALLY_BITS'(TREE_OUT_MAX)) ?
		TREE_OUT_MAX : TREE_OUT_W'(tree_tally_q);

endmodule

>>> rtl/cfdc_chk.sv
// Port-level checker for the culling block, bound to the top level.
// Depends on cluster_frustum_distance_cull_macros.svh.
`include "cluster_frustum_distance_cull_macros.svh"

module cfdc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        cluster_visible,
	input logic        use_impostor,
	input logic [15:0] trees_shown,
	input logic [15:0] visible_cluster_total
);

	`CFDC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(trees_shown) && $stable(visible_cluster_total), "stalled result changed")
	`CFDC_ASSERT_NOW(a_imp_visible, clk, arst_n, out_valid && use_impostor, cluster_visible, "impostor flag on hidden cluster")
	`CFDC_ASSERT_NOW(a_hidden_empty, clk, arst_n, out_valid && !cluster_visible, trees_shown == 16'h0000, "hidden cluster shows trees")
	`CFDC_ASSERT_NOW(a_total_counts, clk, arst_n, out_valid && cluster_visible, visible_cluster_total != 16'h0000, "visible cluster not counted")

endmodule

bind cluster_frustum_distance_cull cfdc_chk u_cfdc_chk (.*);

>>> tb/testbench.sv
// Testbench for cluster_frustum_distance_cull: directed edge cases, a heavy tally pass and
// random cluster traffic, each result checked against an in-bench cull predictor.
// Depends on cfdc_pkg and the cluster_frustum_distance_cull RTL.
module testbench;
	import cfdc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TALLY_HEAVY = 15;
	localparam int TALLY_ITEMS = 20;
	localparam int RANDOM_PHASES = 5;
	localparam int ITEMS_PER_PHASE = 100;
	localparam longint unsigned AXIS_LIMIT = 64'h20000;
	localparam longint signed ONE_Q14 = 64'sd16384;

	typedef struct {
		logic signed [COORD_BITS_DEF-1:0] cx;
		logic signed [COORD_BITS_DEF-1:0] cy;
		logic signed [COORD_BITS_DEF-1:0] cz;
		logic [FIELD_W-1:0] radius;
		logic [FIELD_W-1:0] trees;
		logic start;
	} cluster_req_t;

	typedef struct {
		logic visible;
		logic impostor;
		logic [FIELD_W-1:0] shown;
		logic [CLUSTER_W-1:0] cluster_total;
		logic [TREE_OUT_W-1:0] tree_total;
	} cull_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic in_valid;
	logic in_ready;
	logic signed [COORD_BITS_DEF-1:0] center_x;
	logic signed [COORD_BITS_DEF-1:0] center_y;
	logic signed [COORD_BITS_DEF-1:0] center_z;
	logic [FIELD_W-1:0] sphere_radius;
	logic [FIELD_W-1:0] tree_count;
	logic pass_start;
	logic out_valid;
	logic out_ready;
	logic cluster_visible;
	logic use_impostor;
	logic [FIELD_W-1:0] trees_shown;
	logic [CLUSTER_W-1:0] visible_cluster_total;
	logic [TREE_OUT_W-1:0] visible_tree_total;

	logic [CFG_DATA_W-1:0] cfg_shadow [8];
	logic [CLUSTER_W-1:0] cluster_tally_q;
	logic [TREE_OUT_W-1:0] tree_tally_q;
	cull_result_t expected_q [$];

	int errors = 0;
	int sent_count = 0;
	int visible_count = 0;
	int impostor_count = 0;
	int cycles = 0;
	bit idle_on = 1'b0;
	bit stall_on = 1'b0;

	cluster_frustum_distance_cull dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.sphere_radius(sphere_radius),
		.tree_count(tree_count),
		.pass_start(pass_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cluster_visible(cluster_visible),
		.use_impostor(use_impostor),
		.trees_shown(trees_shown),
		.visible_cluster_total(visible_cluster_total),
		.visible_tree_total(visible_tree_total)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic cull_result_t predict_cull(cluster_req_t r);
		longint signed ctr [NUM_AXES];
		longint signed dlt;
		longint signed acc;
		longint signed rad_q;
		longint unsigned dist_sq;
		longint unsigned mag;
		longint unsigned cull_sq;
		longint unsigned imp_sq;
		logic [CFG_DATA_W-1:0] cam;
		logic [CFG_DATA_W-1:0] dist_cfg;
		logic [CFG_DATA_W-1:0] pl;
		logic keep;
		int k;
		cull_result_t res;
		cam = cfg_shadow[REG_CAMERA];
		dist_cfg = cfg_shadow[REG_DISTANCE];
		ctr[0] = r.cx;
		ctr[1] = r.cy;
		ctr[2] = r.cz;
		dist_sq = 0;
		for (k = 0; k < NUM_AXES; k++) begin
			dlt = ctr[k] - longint'($signed(cam[16*k +: 16]));
			mag = (dlt < 0) ? -dlt : dlt;
			if (mag > AXIS_LIMIT)
				mag = AXIS_LIMIT;
			dist_sq += mag * mag;
		end
		cull_sq = 64'(dist_cfg[15:0]) * 64'(dist_cfg[15:0]);
		imp_sq = 64'(dist_cfg[31:16]) * 64'(dist_cfg[31:16]);
		if (r.start) begin
			cluster_tally_q = '0;
			tree_tally_q = '0;
		end
		keep = (r.trees != 0);
		if (keep && dist_cfg[32]) begin
			if (dist_sq > cull_sq)
				keep = 1'b0;
			rad_q = longint'(r.radius) * ONE_Q14;
			for (k = 0; k < NUM_PLANES; k++) begin
				pl = cfg_shadow[k];
				acc = longint'($signed(pl[15:0])) * ctr[0]
					+ longint'($signed(pl[31:16])) * ctr[1]
					+ longint'($signed(pl[47:32])) * ctr[2]
					+ longint'($signed(pl[63:48])) * ONE_Q14;
				if (acc < -rad_q)
					keep = 1'b0;
			end
		end
		res.visible = keep;
		res.impostor = keep && dist_cfg[33] && (dist_sq > imp_sq);
		res.shown = keep ? r.trees : '0;
		if (keep) begin
			if (cluster_tally_q != '1)
				cluster_tally_q++;
			if (32'hFFFF_FFFF - tree_tally_q < r.trees)
				tree_tally_q = '1;
			else
				tree_tally_q += r.trees;
		end
		res.cluster_total = cluster_tally_q;
		res.tree_total = tree_tally_q;
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		cull_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				want = expected_q.pop_front();
				check_field("cluster_visible", want.visible, cluster_visible);
				check_field("use_impostor", want.impostor, use_impostor);
				check_field("trees_shown", want.shown, trees_shown);
				check_field("visible_cluster_total", want.cluster_total, visible_cluster_total);
				check_field("visible_tree_total", want.tree_total, visible_tree_total);
				visible_count += cluster_visible;
				impostor_count += use_impostor;
			end
		end
	end

	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result-side backpressure
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0)
				hold--;
			else if (!stall_on)
				out_ready <= 1'b1;
			else if (out_ready) begin
				out_ready <= 1'b0;
				hold = gap_len();
			end else begin
				out_ready <= 1'b1;
				hold = $urandom_range(0, 30);
			end
		end
	end

	function automatic cluster_req_t make_cluster(logic signed [15:0] cx, logic signed [15:0] cy,
			logic signed [15:0] cz, logic [15:0] radius, logic [15:0] trees, logic start);
		cluster_req_t r;
		r.cx = cx;
		r.cy = cy;
		r.cz = cz;
		r.radius = radius;
		r.trees = trees;
		r.start = start;
		return r;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] plane_word(logic [15:0] w, logic [15:0] nz,
			logic [15:0] ny, logic [15:0] nx);
		plane_t p;
		p.w = w;
		p.nz = nz;
		p.ny = ny;
		p.nx = nx;
		return CFG_DATA_W'(p);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] dist_word(logic [15:0] cull_d, logic [15:0] imp_d,
			logic cull_on, logic lod_on);
		return {30'd0, lod_on, cull_on, imp_d, cull_d};
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		case (idx)
			REG_CAMERA: cfg_shadow[idx] = value & 64'h0000_FFFF_FFFF_FFFF;
			REG_DISTANCE: cfg_shadow[idx] = value & 64'h0000_0003_FFFF_FFFF;
			default: cfg_shadow[idx] = value;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic send_cluster(cluster_req_t r);
		int gap;
		gap = idle_on ? gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		center_x <= r.cx;
		center_y <= r.cy;
		center_z <= r.cz;
		sphere_radius <= r.radius;
		tree_count <= r.trees;
		pass_start <= r.start;
		do @(posedge clk); while (!in_ready);
		expected_q = {expected_q, predict_cull(r)};
		sent_count++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	// all registers at reset value: culling off, only the empty test applies
	task automatic test_power_on();
		send_cluster(make_cluster(16'sd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 1'b1));
		send_cluster(make_cluster(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 1'b0));
		send_cluster(make_cluster(16'sh8000, 16'sh8000, 16'sh8000, 16'd0, 16'd1, 1'b0));
		send_cluster(make_cluster(16'sh8000, 16'sh7FFF, 16'sd0, 16'hFFFF, 16'd0, 1'b0));
		send_cluster(make_cluster(16'sd5, -16'sd5, 16'sd0, 16'd3, 16'd1, 1'b1));
		drain_results();
	endtask

	task automatic test_distance_thresholds();
		write_reg(REG_CAMERA, {16'hDEAD, 16'sd300, -16'sd200, 16'sd100});
		write_reg(REG_DISTANCE, dist_word(16'd500, 16'd300, 1'b1, 1'b1));
		send_cluster(make_cluster(16'sd600, -16'sd200, 16'sd300, 16'd0, 16'd7, 1'b1));
		send_cluster(make_cluster(16'sd100, 16'sd301, 16'sd300, 16'd0, 16'd7, 1'b0));
		send_cluster(make_cluster(16'sd100, -16'sd200, 16'sd0, 16'd0, 16'd7, 1'b0));
		send_cluster(make_cluster(16'sd100, -16'sd200, -16'sd1, 16'd0, 16'd7, 1'b0));
		drain_results();
		write_reg(REG_DISTANCE, dist_word(16'd500, 16'd300, 1'b1, 1'b0));
		send_cluster(make_cluster(16'sd600, -16'sd200, 16'sd300, 16'd0, 16'd9, 1'b0));
		drain_results();
		// opposite corners of the coordinate range
		write_reg(REG_CAMERA, {16'h0000, 16'sh8000, 16'sh8000, 16'sh8000});
		write_reg(REG_DISTANCE, dist_word(16'hFFFF, 16'hFFFE, 1'b1, 1'b1));
		send_cluster(make_cluster(16'sh7FFF, 16'sh8000, 16'sh8000, 16'd0, 16'd2, 1'b0));
		send_cluster(make_cluster(16'sh7FFF, 16'sh8001, 16'sh8000, 16'd0, 16'd2, 1'b0));
		drain_results();
		write_reg(REG_DISTANCE, dist_word(16'hFFFF, 16'hFFFE, 1'b0, 1'b1));
		send_cluster(make_cluster(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0, 16'd2, 1'b0));
		drain_results();
	endtask

	task automatic test_planes();
		int p;
		write_reg(REG_CAMERA, 64'd0);
		write_reg(REG_DISTANCE, dist_word(16'hFFFF, 16'd0, 1'b1, 1'b0));
		for (p = 0; p < NUM_PLANES; p++)
			write_reg(reg_idx_t'(p), 64'd0);
		for (p = 0; p < NUM_PLANES; p++) begin
			write_reg(reg_idx_t'(p), plane_word(16'd0, 16'd0, 16'd0, 16'sd16384));
			// touching the plane is kept, one unit short of it is culled
			if (p == 0)
				send_cluster(make_cluster(-16'sd10, 16'sd0, 16'sd0, 16'd10, 16'd4, 1'b1));
			send_cluster(make_cluster(-16'sd10, 16'sd0, 16'sd0, 16'd9, 16'd4, 1'b0));
			drain_results();
			write_reg(reg_idx_t'(p), 64'd0);
		end
		write_reg(REG_PLANE_B, plane_word(16'sd5, 16'd0, 16'd0, 16'sd16384));
		send_cluster(make_cluster(-16'sd14, 16'sd0, 16'sd0, 16'd9, 16'd4, 1'b0));
		drain_results();
		write_reg(REG_PLANE_C, plane_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
		send_cluster(make_cluster(16'sd20, 16'sd20, 16'sd20, 16'hFFFF, 16'd4, 1'b0));
		drain_results();
		write_reg(REG_DISTANCE, dist_word(16'hFFFF, 16'd0, 1'b0, 1'b0));
		send_cluster(make_cluster(16'sd20, 16'sd20, 16'sd20, 16'hFFFF, 16'd4, 1'b0));
		drain_results();
	endtask

	// one pass of heavy clusters, both running totals accumulating back to back
	task automatic test_tally_run();
		int n;
		logic [15:0] trees;
		write_reg(REG_DISTANCE, 64'd0);
		for (n = 0; n < TALLY_ITEMS; n++) begin
			trees = (n < TALLY_HEAVY) ? 16'hFFFF : 16'($urandom_range(50000, 65535));
			send_cluster(make_cluster(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), trees, n == 0));
		end
		drain_results();
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_plane();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			return 64'd0;
		if (roll < 7)
			return {32'($urandom), 32'($urandom)};
		return plane_word(16'($urandom_range(0, 32767)), 16'($urandom), 16'($urandom),
			16'($urandom));
	endfunction

	function automatic cluster_req_t random_cluster();
		cluster_req_t r;
		logic [CFG_DATA_W-1:0] cam;
		int roll;
		cam = cfg_shadow[REG_CAMERA];
		if ($urandom_range(0, 9) < 6) begin
			r.cx = cam[15:0] + 16'($urandom_range(0, 4095)) - 16'd2048;
			r.cy = cam[31:16] + 16'($urandom_range(0, 4095)) - 16'd2048;
			r.cz = cam[47:32] + 16'($urandom_range(0, 4095)) - 16'd2048;
		end else begin
			r.cx = 16'($urandom);
			r.cy = 16'($urandom);
			r.cz = 16'($urandom);
		end
		roll = $urandom_range(0, 9);
		if (roll < 4)
			r.radius = 16'($urandom_range(0, 255));
		else if (roll < 7)
			r.radius = 16'($urandom_range(1000, 20000));
		else
			r.radius = 16'($urandom);
		roll = $urandom_range(0, 19);
		if (roll < 2)
			r.trees = 16'd0;
		else if (roll < 3)
			r.trees = 16'hFFFF;
		else
			r.trees = 16'($urandom);
		r.start = ($urandom_range(0, 99) < 3);
		return r;
	endfunction

	task automatic test_random_traffic();
		int phase;
		int n;
		int p;
		logic [15:0] cull_d;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			for (p = 0; p < NUM_PLANES; p++)
				write_reg(reg_idx_t'(p), random_plane());
			case (phase)
				0: begin
					write_reg(REG_CAMERA, 64'hFFFF_FFFF_FFFF_FFFF);
					write_reg(REG_DISTANCE, 64'hFFFF_FFFF_FFFF_FFFF);
				end
				1: begin
					write_reg(REG_CAMERA, {16'h0000, 16'sh8000, 16'sh7FFF, 16'sh8000});
					write_reg(REG_DISTANCE, 64'd0);
				end
				default: begin
					cull_d = 16'($urandom_range(200, 65535));
					write_reg(REG_CAMERA, {32'($urandom), 32'($urandom)});
					write_reg(REG_DISTANCE, dist_word(cull_d, 16'($urandom_range(0, cull_d)),
						$urandom_range(0, 3) != 0, 1'($urandom_range(0, 1))));
				end
			endcase
			idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
			stall_on = (phase != 0) && ($urandom_range(0, 3) != 0);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					drain_results();
				send_cluster(random_cluster());
			end
			drain_results();
			idle_on = 1'b0;
			stall_on = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		center_x = '0;
		center_y = '0;
		center_z = '0;
		sphere_radius = '0;
		tree_count = '0;
		pass_start = 1'b0;
		out_ready = 1'b1;
		foreach (cfg_shadow[i])
			cfg_shadow[i] = '0;
		cluster_tally_q = '0;
		tree_tally_q = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_power_on();
		test_distance_thresholds();
		test_planes();
		test_tally_run();
		test_random_traffic();

		drain_results();
		repeat (8) @(posedge clk);
		if (expected_q.size() != 0)
			errors++;
		$display("Covered: reset defaults, distance and plane edges, a heavy tally pass,");
		$display("  %0d random phases with idle gaps and result stalls", RANDOM_PHASES);
		$display("Clusters: %0d sent, %0d visible, %0d impostor; %0d mismatches",
			sent_count, visible_count, impostor_count, errors);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
